FILE: hw/rtl/fbba_pkg.sv
package fbba_pkg;

   // Geometry of the bitmap
   localparam int NUM_BLOCKS = 1024;
   localparam int WORD_BITS  = 32;
   localparam int WORD_COUNT = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W     = $clog2(WORD_COUNT);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int BLK_W      = 10;
   localparam int CNT_W      = 11;

   localparam logic [CNT_W-1:0]  LIMIT_MAX       = CNT_W'(NUM_BLOCKS);
   localparam logic [CNT_W-1:0]  TOTAL_RESET     = CNT_W'(1024);
   localparam logic [ADDR_W-1:0] LAST_WORD       = ADDR_W'(WORD_COUNT - 1);

   // Request codes
   typedef enum logic [1:0] {
      REQ_MARK_USED = 2'd0,
      REQ_MARK_FREE = 2'd1,
      REQ_TEST_FREE = 2'd2,
      REQ_FIND_FREE = 2'd3
   } req_code_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MODIFY,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Result of the word evaluation unit
   typedef struct packed {
      logic              hit;        // lowest free bit lies below the limit
      logic              stop;       // no free block can follow this word
      logic [BLK_W-1:0]  index;      // block number of the lowest free bit
      logic              bit_free;   // selected bit is free
      logic [WORD_BITS-1:0] new_word; // word after the mark
   } eval_type;

endpackage

FILE: hw/rtl/free_block_bitmap_allocator.sv
// First-fit free-block allocator over a used/free bitmap (1 = used).
// Request channel (req_valid/req_ready) carries req_type and
// req_block_index; result channel (rsp_valid/rsp_ready) returns one
// transaction per request with result_index, found, is_free, bad_index.
// csr_wr_en/csr_wr_data write the block count; write only while idle.
// A request with a bad index goes straight to the done state; mark and test
// pass through read and modify; a find reads and then scans 32-bit words
// until a hit or the end (at most 32 words). From the done state the
// result moves to the result register. The scan reads one word per cycle
// from the single read port of the bitmap memory; a new request is taken
// the cycle after the last one has moved to the result register.
// Reset clears all per-word valid bits at once, so every block reads as
// free; the block count returns to 1024. No clearing pass is needed.
// A stalled receiver holds the result register; one further request can
// complete behind it and waits in the done state until the register empties.
module free_block_bitmap_allocator
   import fbba_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_type,
   input  logic [BLK_W-1:0] req_block_index,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [BLK_W-1:0] rsp_result_index,
   output logic             rsp_found,
   output logic             rsp_is_free,
   output logic             rsp_bad_index,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     total_ff;
   logic [CNT_W-1:0]     limit;
   req_code_type         op_ff;
   logic [BLK_W-1:0]     blk_ff;
   logic [ADDR_W-1:0]    ptr_ff;
   logic [BLK_W-1:0]     pend_index_ff;
   logic                 pend_found_ff, pend_free_ff, pend_bad_ff;
   logic                 rsp_valid_ff;
   logic [BLK_W-1:0]     rsp_index_ff;
   logic                 rsp_found_ff, rsp_free_ff, rsp_bad_ff;

   logic                 req_fire, rsp_free_slot, req_bad;
   logic                 rd_en, wr_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic [WORD_BITS-1:0] rd_data;
   eval_type             ev;

   // Effective limit and index check
   assign limit    = (total_ff > LIMIT_MAX) ? LIMIT_MAX : total_ff;
   assign req_bad  = !({1'b0, req_block_index} < limit);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free_slot = !rsp_valid_ff || rsp_ready;

   fbba_bitmap u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (blk_ff[BLK_W-1:BIT_W]),
      .wr_data (ev.new_word)
   );

   fbba_word_eval u_eval (
      .word      (rd_data),
      .word_addr ((state_ff == ST_SCAN) ? ptr_ff : blk_ff[BLK_W-1:BIT_W]),
      .bit_sel   (blk_ff[BIT_W-1:0]),
      .op        (op_ff),
      .limit     (limit),
      .result    (ev)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_code_type'(req_type) != REQ_FIND_FREE && req_bad) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = (op_ff == REQ_FIND_FREE) ? ST_SCAN : ST_MODIFY;
         end
         ST_MODIFY: state_in = ST_DONE;
         ST_SCAN: begin
            if (ev.hit || ev.stop) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free_slot) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = blk_ff[BLK_W-1:BIT_W];
      wr_en   = 1'b0;
      case (state_ff)
         ST_READ: begin
            rd_en = 1'b1;
            if (op_ff == REQ_FIND_FREE) begin
               rd_addr = ptr_ff;
            end
         end
         ST_SCAN: begin
            rd_en   = 1'b1;
            rd_addr = ptr_ff + ADDR_W'(1);
         end
         ST_MODIFY: begin
            wr_en = (op_ff == REQ_MARK_USED) || (op_ff == REQ_MARK_FREE);
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= TOTAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            total_ff <= csr_wr_data;
         end
         if (state_ff == ST_DONE && rsp_free_slot) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request, scan pointer and pending result
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff         <= req_code_type'(req_type);
         blk_ff        <= req_block_index;
         ptr_ff        <= '0;
         pend_index_ff <= '0;
         pend_found_ff <= 1'b0;
         pend_free_ff  <= 1'b0;
         pend_bad_ff   <= (req_code_type'(req_type) != REQ_FIND_FREE) && req_bad;
      end
      if (state_ff == ST_MODIFY && op_ff == REQ_TEST_FREE) begin
         pend_free_ff <= ev.bit_free;
      end
      if (state_ff == ST_SCAN) begin
         if (ev.hit) begin
            pend_index_ff <= ev.index;
            pend_found_ff <= 1'b1;
         end else if (!ev.stop) begin
            ptr_ff <= ptr_ff + ADDR_W'(1);
         end
      end
      if (state_ff == ST_DONE && rsp_free_slot) begin
         rsp_index_ff <= pend_index_ff;
         rsp_found_ff <= pend_found_ff;
         rsp_free_ff  <= pend_free_ff;
         rsp_bad_ff   <= pend_bad_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_is_free      = rsp_free_ff;
   assign rsp_bad_index    = rsp_bad_ff;

endmodule

FILE: hw/rtl/fbba_bitmap.sv
module fbba_bitmap
   import fbba_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [WORD_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [WORD_BITS-1:0] wr_data
);

   logic [WORD_BITS-1:0]  mem_ff [WORD_COUNT];
   logic [WORD_COUNT-1:0] valid_ff;
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic                  rd_valid_ff;

   // Word storage, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // Per-word valid bits; an unwritten word reads as all free
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

FILE: hw/rtl/fbba_word_eval.sv
module fbba_word_eval
   import fbba_pkg::*;
(
   input  logic [WORD_BITS-1:0] word,
   input  logic [ADDR_W-1:0]    word_addr,
   input  logic [BIT_W-1:0]     bit_sel,
   input  req_code_type         op,
   input  logic [CNT_W-1:0]     limit,
   output eval_type             result
);

   logic             any_free;
   logic [BIT_W-1:0] first_pos;
   logic [BLK_W-1:0] cand;
   logic             below;

   // Lowest zero bit of the word
   always_comb begin
      any_free  = 1'b0;
      first_pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            any_free  = 1'b1;
            first_pos = BIT_W'(i);
         end
      end
   end

   assign cand  = {word_addr, first_pos};
   assign below = {1'b0, cand} < limit;

   // Find, test and mark share this unit
   always_comb begin
      result.hit      = any_free && below;
      result.stop     = (any_free && !below) || (word_addr == LAST_WORD);
      result.index    = cand;
      result.bit_free = !word[bit_sel];
      result.new_word = word;
      if (op == REQ_MARK_USED) begin
         result.new_word[bit_sel] = 1'b1;
      end else begin
         result.new_word[bit_sel] = 1'b0;
      end
   end

endmodule
